>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the column qc filter: concurrent checks on the rising
// clock edge, switched off while reset is held and left out of synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> sv/ccqf_pkg.sv
// ---------------------------------------------------------------------------
// ccqf_pkg
// Widths, codes and beat types shared by the column qc filter modules.
// ---------------------------------------------------------------------------
package ccqf_pkg;

  // column store sizing
  localparam int COLUMNS = 4096;
  localparam int ADDR_W  = $clog2(COLUMNS);

  // field widths
  localparam int MODE_W = 2;
  localparam int COL_W  = 12;
  localparam int VAL_W  = 24;
  localparam int SUM_W  = 44;
  localparam int CNT_W  = 20;
  localparam int FRAC_W = 17;

  // mito product split into two partial products
  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PPL_W  = FRAC_W + LO_W;
  localparam int PPH_W  = FRAC_W + HI_W;
  localparam int PROD_W = FRAC_W + SUM_W;
  localparam int FRAC_SHIFT = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SUM_W;

  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  // item modes
  localparam logic [MODE_W-1:0] MODE_ACC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QRY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FEAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FEAT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MITO  = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  column;
    logic [VAL_W-1:0]  value;
    logic              row_is_mito;
  } item_t;

  // one column entry of the store
  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] mito;
    logic [CNT_W-1:0] feat;
  } stats_t;

  localparam int STATS_W = $bits(stats_t);

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    stats_t            data;
  } wr_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [COL_W-1:0] column;
    stats_t           stats;
  } query_t;

  typedef struct packed {
    logic [VAL_W-1:0]  threshold;
    logic [SUM_W-1:0]  min_total;
    logic [SUM_W-1:0]  max_total;
    logic [CNT_W-1:0]  min_feat;
    logic [CNT_W-1:0]  max_feat;
    logic [FRAC_W-1:0] mito_limit;
  } limits_t;

endpackage

>>> sv/cell_column_qc_filter_unit.sv
// ---------------------------------------------------------------------------
// cell_column_qc_filter_unit
// Per-column qc statistics (total, mito total, feature count) kept in one
// column memory, with query beats returning the statistics and a pass flag.
// ---------------------------------------------------------------------------
// a query result strobe follows the accum stage register and the pass stage registers
// throughput: one beat per cycle while busy is low; the column memory is read at accept and
//   written in the cycle after, with the last write forwarded on a column match
// reset: busy stays high while the memory is cleared one column per cycle, all COLUMNS (4096)
//   of them; configuration writes are taken throughout
// results are held for one cycle only, the receiver cannot stall them
`include "assert_macros.svh"

module cell_column_qc_filter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ccqf_pkg::MODE_W-1:0]      in_mode,
  input  logic [ccqf_pkg::COL_W-1:0]       in_column,
  input  logic [ccqf_pkg::VAL_W-1:0]       in_value,
  input  logic                             in_row_is_mito,
  output logic                             out_strobe,
  output logic [ccqf_pkg::COL_W-1:0]       out_column,
  output logic                             out_passes,
  output logic [ccqf_pkg::SUM_W-1:0]       out_total_sum,
  output logic [ccqf_pkg::SUM_W-1:0]       out_mito_sum,
  output logic [ccqf_pkg::CNT_W-1:0]       out_feature_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ccqf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccqf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ccqf_pkg::*;

  limits_t           lim_r;
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic              item_valid;
  item_t             item;
  stats_t            rd_data;
  wr_t               wr;
  query_t            query;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  stats_t            ram_wdata;

  // input beat
  assign busy       = clr_active_r;
  assign item_valid = start && !busy;
  assign item.mode        = in_mode;
  assign item.column      = in_column;
  assign item.value       = in_value;
  assign item.row_is_mito = in_row_is_mito;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.threshold  <= '0;
      lim_r.min_total  <= '0;
      lim_r.max_total  <= SUM_MAX;
      lim_r.min_feat   <= '0;
      lim_r.max_feat   <= CNT_MAX;
      lim_r.mito_limit <= FRAC_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: lim_r.threshold  <= cfg_data[VAL_W-1:0];
        REG_MIN_TOTAL: lim_r.min_total  <= cfg_data[SUM_W-1:0];
        REG_MAX_TOTAL: lim_r.max_total  <= cfg_data[SUM_W-1:0];
        REG_MIN_FEAT:  lim_r.min_feat   <= cfg_data[CNT_W-1:0];
        REG_MAX_FEAT:  lim_r.max_feat   <= cfg_data[CNT_W-1:0];
        REG_MAX_MITO:  lim_r.mito_limit <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(COLUMNS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // memory write port shared by clearing pass and update stage
  assign ram_we    = clr_active_r || wr.en;
  assign ram_waddr = clr_active_r ? clr_addr_r : wr.addr;
  assign ram_wdata = clr_active_r ? '0 : wr.data;

  ccqf_ram #(
    .WIDTH (STATS_W),
    .DEPTH (COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ADDR_W'(in_column)),
    .rdata (rd_data)
  );

  ccqf_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .rd_data    (rd_data),
    .threshold  (lim_r.threshold),
    .wr         (wr),
    .query      (query)
  );

  ccqf_pass u_pass (
    .clk               (clk),
    .rst_n             (rst_n),
    .query             (query),
    .lim               (lim_r),
    .out_strobe        (out_strobe),
    .out_column        (out_column),
    .out_passes        (out_passes),
    .out_total_sum     (out_total_sum),
    .out_mito_sum      (out_mito_sum),
    .out_feature_count (out_feature_count)
  );

  // checks
  `ASSERT_PROP(a_query_latency, clk, rst_n, (item_valid && (in_mode == MODE_QRY)) |-> ##3 out_strobe, "query beat without result three cycles later")
  `ASSERT_NEVER(a_write_clash, clk, rst_n, clr_active_r && wr.en, "update write during clearing pass")
  `ASSERT_NEVER(a_query_in_clear, clk, rst_n, clr_active_r && query.valid, "query in flight during clearing pass")

endmodule

>>> sv/ccqf_ram.sv
// ---------------------------------------------------------------------------
// ccqf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module ccqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/ccqf_accum.sv
// ---------------------------------------------------------------------------
// ccqf_accum
// Read-modify-write stage: takes the store read data for the beat accepted in
// the previous cycle, forwards the previous write on a column match, and produces the
// store write and the query statistics.
// ---------------------------------------------------------------------------
module ccqf_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  ccqf_pkg::item_t               item,
  input  ccqf_pkg::stats_t              rd_data,
  input  logic [ccqf_pkg::VAL_W-1:0]    threshold,
  output ccqf_pkg::wr_t                 wr,
  output ccqf_pkg::query_t              query
);
  import ccqf_pkg::*;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  stats_t            fwd_data_r;

  logic              s1_ok;
  logic [ADDR_W-1:0] s1_addr;
  stats_t            cur;
  stats_t            upd;
  logic [SUM_W:0]    tot_sum;
  logic [SUM_W:0]    mito_sum;

  // stage register for the beat whose read is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= item;
  end

  // column range check and store address
  assign s1_ok   = int'(s1_item_r.column) < COLUMNS;
  assign s1_addr = ADDR_W'(s1_item_r.column);

  // forward last cycle's write, the memory read missed it
  assign cur = (fwd_valid_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : rd_data;

  // saturating update
  always_comb begin
    tot_sum  = {1'b0, cur.total} + (SUM_W+1)'(s1_item_r.value);
    mito_sum = {1'b0, cur.mito} + (SUM_W+1)'(s1_item_r.value);
    upd      = cur;
    upd.total = tot_sum[SUM_W] ? SUM_MAX : tot_sum[SUM_W-1:0];
    if (s1_item_r.row_is_mito) begin
      upd.mito = mito_sum[SUM_W] ? SUM_MAX : mito_sum[SUM_W-1:0];
    end
    if ((s1_item_r.value > threshold) && (cur.feat != CNT_MAX)) begin
      upd.feat = cur.feat + CNT_W'(1);
    end
  end

  // store write for accumulate and clear
  always_comb begin
    wr.en   = s1_valid_r && s1_ok &&
              ((s1_item_r.mode == MODE_ACC) || (s1_item_r.mode == MODE_CLR));
    wr.addr = s1_addr;
    wr.data = (s1_item_r.mode == MODE_CLR) ? '0 : upd;
  end

  // query beat towards the pass test
  always_comb begin
    query.valid  = s1_valid_r && (s1_item_r.mode == MODE_QRY);
    query.ok     = s1_ok;
    query.column = s1_item_r.column;
    query.stats  = cur;
  end

  // forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= wr.addr;
    fwd_data_r <= wr.data;
  end

endmodule

>>> sv/ccqf_pass.sv
// ---------------------------------------------------------------------------
// ccqf_pass
// Pass test for a queried column: limit compares and the mito share
// product in split partial products, then the final compare and the
// result register.
// ---------------------------------------------------------------------------
module ccqf_pass (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccqf_pkg::query_t            query,
  input  ccqf_pkg::limits_t           lim,
  output logic                        out_strobe,
  output logic [ccqf_pkg::COL_W-1:0]  out_column,
  output logic                        out_passes,
  output logic [ccqf_pkg::SUM_W-1:0]  out_total_sum,
  output logic [ccqf_pkg::SUM_W-1:0]  out_mito_sum,
  output logic [ccqf_pkg::CNT_W-1:0]  out_feature_count
);
  import ccqf_pkg::*;

  stats_t           st;
  logic             lim_ok;

  logic             q2_valid_r;
  logic [COL_W-1:0] q2_col_r;
  stats_t           q2_stats_r;
  logic             q2_lim_ok_r;
  logic [PPL_W-1:0] pp_lo_r;
  logic [PPH_W-1:0] pp_hi_r;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] mito_scaled;

  logic             out_valid_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_pass_r;
  stats_t           out_stats_r;

  // out-of-range column reads as empty and fails
  assign st = query.ok ? query.stats : '0;

  assign lim_ok = query.ok &&
                  (st.total <= lim.max_total) && (st.total >= lim.min_total) &&
                  (st.feat <= lim.max_feat) && (st.feat >= lim.min_feat);

  // first stage: compares and partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_valid_r <= 1'b0;
    end else begin
      q2_valid_r <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    q2_col_r    <= query.column;
    q2_stats_r  <= st;
    q2_lim_ok_r <= lim_ok;
    pp_lo_r     <= PPL_W'(lim.mito_limit) * PPL_W'(st.total[LO_W-1:0]);
    pp_hi_r     <= PPH_W'(lim.mito_limit) * PPH_W'(st.total[SUM_W-1:LO_W]);
  end

  // second stage: sum of partial products against scaled mito sum
  assign prod        = (PROD_W'(pp_hi_r) << LO_W) + PROD_W'(pp_lo_r);
  assign mito_scaled = PROD_W'(q2_stats_r.mito) << FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_col_r   <= q2_col_r;
    out_stats_r <= q2_stats_r;
    out_pass_r  <= q2_lim_ok_r && !(mito_scaled > prod);
  end

  // result beat
  assign out_strobe        = out_valid_r;
  assign out_column        = out_col_r;
  assign out_passes        = out_pass_r;
  assign out_total_sum     = out_stats_r.total;
  assign out_mito_sum      = out_stats_r.mito;
  assign out_feature_count = out_stats_r.feat;

endmodule

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the column qc filter unit: directed beats with
// hand-worked answers, a burst of full-scale entries on one column, then
// random phases with their own limit settings, each query result checked
// against a predictor of the column stores and the pass test.
// ---------------------------------------------------------------------------
module tb;
  import ccqf_pkg::*;

  // unused item mode and register indexes past the end of the list
  localparam logic [MODE_W-1:0]    MODE_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 188;
  localparam int HOT_COLS        = 6;
  localparam int BURST_BEATS     = 16;
  localparam int HOLD_CYCLES     = 6;
  localparam int QUIET_WAIT      = 2000;
  localparam int CYCLE_LIMIT     = 200_000;
  // the receiver cannot stall, so gaps come only from the sender, at these idle percentages
  localparam int IDLE_PCT [PHASES] = '{0, 83, 0, 31, 83, 0, 31, 83};

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             passes;
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] mito;
    logic [CNT_W-1:0] features;
  } report_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    item_t                  beat;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    report_t                want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [MODE_W-1:0]     in_mode = '0;
  logic [COL_W-1:0]      in_column = '0;
  logic [VAL_W-1:0]      in_value = '0;
  logic                  in_row_is_mito = 1'b0;
  logic                  out_strobe;
  logic [COL_W-1:0]      out_column;
  logic                  out_passes;
  logic [SUM_W-1:0]      out_total_sum;
  logic [SUM_W-1:0]      out_mito_sum;
  logic [CNT_W-1:0]      out_feature_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: column stores and the limit registers
  logic [SUM_W-1:0] col_total    [COLUMNS];
  logic [SUM_W-1:0] col_mito     [COLUMNS];
  logic [CNT_W-1:0] col_features [COLUMNS];
  limits_t          lim;

  report_t   pending_reports [$];
  stim_row_t directed_rows [$];
  int        mismatches = 0;
  int        cycle_count = 0;

  cell_column_qc_filter_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_column         (in_column),
    .in_value          (in_value),
    .in_row_is_mito    (in_row_is_mito),
    .out_strobe        (out_strobe),
    .out_column        (out_column),
    .out_passes        (out_passes),
    .out_total_sum     (out_total_sum),
    .out_mito_sum      (out_mito_sum),
    .out_feature_count (out_feature_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------
  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, logic [VAL_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(v);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // mito share tested as mito * 2^16 > fraction * total, so an empty column passes the mito test
  function automatic logic meets_limits(logic [SUM_W-1:0] tot, logic [SUM_W-1:0] mito,
                                        logic [CNT_W-1:0] feat);
    logic [63:0] mito_scaled;
    logic [63:0] allowed;
    mito_scaled = 64'(mito) << FRAC_SHIFT;
    allowed     = 64'(lim.mito_limit) * 64'(tot);
    return tot <= lim.max_total && tot >= lim.min_total &&
           feat <= lim.max_feat && feat >= lim.min_feat && !(mito_scaled > allowed);
  endfunction

  // every 12-bit column lies inside the store, so no range test is needed
  function automatic void track_beat(item_t b);
    case (b.mode)
      MODE_ACC: begin
        col_total[b.column] = sat_sum(col_total[b.column], b.value);
        if (b.row_is_mito)
          col_mito[b.column] = sat_sum(col_mito[b.column], b.value);
        if (b.value > lim.threshold && col_features[b.column] != CNT_MAX)
          col_features[b.column] = col_features[b.column] + CNT_W'(1);
      end
      MODE_QRY: begin
        pending_reports.insert(pending_reports.size(), report_t'{b.column,
            meets_limits(col_total[b.column], col_mito[b.column], col_features[b.column]),
            col_total[b.column], col_mito[b.column], col_features[b.column]});
      end
      MODE_CLR: begin
        col_total[b.column]    = '0;
        col_mito[b.column]     = '0;
        col_features[b.column] = '0;
      end
      default: ; // unused mode leaves everything alone
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------
  // hold the beat until an edge with start high and busy low
  task automatic issue_beat(item_t b);
    start          <= 1'b1;
    in_mode        <= b.mode;
    in_column      <= b.column;
    in_value       <= b.value;
    in_row_is_mito <= b.row_is_mito;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // random gap with junk on the fields
  task automatic sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start          <= 1'b0;
      in_mode        <= MODE_W'($urandom);
      in_column      <= COL_W'($urandom);
      in_value       <= VAL_W'($urandom);
      in_row_is_mito <= 1'($urandom);
      @(posedge clk);
    end
  endtask

  // stop sending, let outstanding results arrive, then cover the tail latency
  task automatic await_quiet();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0 && waited < QUIET_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_THRESHOLD: lim.threshold  = data[VAL_W-1:0];
      REG_MIN_TOTAL: lim.min_total  = data[SUM_W-1:0];
      REG_MAX_TOTAL: lim.max_total  = data[SUM_W-1:0];
      REG_MIN_FEAT:  lim.min_feat   = data[CNT_W-1:0];
      REG_MAX_FEAT:  lim.max_feat   = data[CNT_W-1:0];
      REG_MAX_MITO:  lim.mito_limit = data[FRAC_W-1:0];
      default: ; // index past the list is dropped
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // limits per phase: both extremes, then random values; junk above each width
  task automatic load_phase_limits(int p);
    logic [CFG_DATA_W-1:0] junk;
    limits_t nxt;
    junk = CFG_DATA_W'({$urandom, $urandom});
    case (p)
      0: nxt = limits_t'{'0, '0, SUM_MAX, '0, CNT_MAX, FRAC_ONE};
      1: nxt = limits_t'{'1, SUM_MAX, SUM_MAX, CNT_MAX, CNT_MAX, FRAC_ONE};
      2: nxt = limits_t'{'0, '0, '0, '0, '0, '0};
      default: begin
        nxt.threshold  = ($urandom_range(3) == 0) ? VAL_W'($urandom)
                                                  : VAL_W'($urandom_range(4095));
        nxt.min_total  = SUM_W'($urandom_range(1 << 26));
        nxt.max_total  = nxt.min_total + SUM_W'($urandom_range(1 << 29));
        nxt.min_feat   = CNT_W'($urandom_range(6));
        nxt.max_feat   = nxt.min_feat + CNT_W'($urandom_range(25));
        nxt.mito_limit = FRAC_W'($urandom_range(65536));
      end
    endcase
    write_limit(REG_THRESHOLD, {junk[CFG_DATA_W-1:VAL_W], nxt.threshold});
    write_limit(REG_MIN_TOTAL, nxt.min_total);
    write_limit(REG_MAX_TOTAL, nxt.max_total);
    write_limit(REG_MIN_FEAT, {junk[CFG_DATA_W-1:CNT_W], nxt.min_feat});
    write_limit(REG_MAX_FEAT, {junk[CFG_DATA_W-1:CNT_W], nxt.max_feat});
    write_limit(REG_MAX_MITO, {junk[CFG_DATA_W-1:FRAC_W], nxt.mito_limit});
    write_limit(p[0] ? REG_UNUSED_7 : REG_UNUSED_6, junk);
  endtask

  // ---------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------
  function automatic void add_beat(logic [MODE_W-1:0] m, logic [COL_W-1:0] c,
                                   logic [VAL_W-1:0] v, logic mt);
    stim_row_t r;
    r.kind  = ROW_BEAT;
    r.beat  = item_t'{m, c, v, mt};
    r.idx   = '0;
    r.data  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // query with its answer worked out by hand; value and mito flag are ignored
  function automatic void add_check(logic [COL_W-1:0] c, logic pass, logic [SUM_W-1:0] tot,
                                    logic [SUM_W-1:0] mito, logic [CNT_W-1:0] feat);
    stim_row_t r;
    r.kind  = ROW_BEAT;
    r.beat  = item_t'{MODE_QRY, c, {VAL_W{1'b1}}, 1'b1};
    r.idx   = '0;
    r.data  = '0;
    r.typed = 1'b1;
    r.want  = report_t'{c, pass, tot, mito, feat};
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind  = ROW_REG;
    r.beat  = '0;
    r.idx   = idx;
    r.data  = data;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  task automatic check_field(string what, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : report_check
    report_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result for column %0h with none expected", $time, out_column);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("column", SUM_W'(want.column), SUM_W'(out_column));
        check_field("passes", SUM_W'(want.passes), SUM_W'(out_passes));
        check_field("total_sum", want.total, out_total_sum);
        check_field("mito_sum", want.mito, out_mito_sum);
        check_field("feature_count", SUM_W'(want.features), SUM_W'(out_feature_count));
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    item_t            b;
    logic [COL_W-1:0] hot [HOT_COLS];
    int unsigned      sel;
    longint           near;

    foreach (col_total[i]) begin
      col_total[i]    = '0;
      col_mito[i]     = '0;
      col_features[i] = '0;
    end
    lim.threshold  = '0;
    lim.min_total  = '0;
    lim.max_total  = SUM_MAX;
    lim.min_feat   = '0;
    lim.max_feat   = CNT_MAX;
    lim.mito_limit = FRAC_ONE;

    // empty columns pass, edge columns, unused mode, clear
    add_check(12'd0, 1'b1, '0, '0, '0);
    add_check(12'd4095, 1'b1, '0, '0, '0);
    add_beat(MODE_ACC, 12'd4095, 24'hFFFFFF, 1'b1);
    add_check(12'd4095, 1'b1, 44'hFFFFFF, 44'hFFFFFF, 20'd1);
    add_beat(MODE_ACC, 12'd4095, 24'h0, 1'b0);
    add_beat(MODE_NONE, 12'd4095, 24'hFFFFFF, 1'b1);
    add_check(12'd4095, 1'b1, 44'hFFFFFF, 44'hFFFFFF, 20'd1);
    add_beat(MODE_CLR, 12'd4095, 24'hFFFFFF, 1'b1);
    add_check(12'd4095, 1'b1, '0, '0, '0);
    // detection is strictly above the threshold
    add_reg(REG_THRESHOLD, 44'd100);
    add_beat(MODE_ACC, 12'd1, 24'd100, 1'b0);
    add_beat(MODE_ACC, 12'd1, 24'd101, 1'b1);
    add_beat(MODE_QRY, 12'd1, 24'd0, 1'b0);
    // zero mito share: any mito fails, an empty column still passes
    add_reg(REG_MAX_MITO, 44'd0);
    add_beat(MODE_QRY, 12'd1, 24'd0, 1'b0);
    add_check(12'd0, 1'b1, '0, '0, '0);
    // writes past the register list change nothing
    add_reg(REG_UNUSED_6, SUM_MAX);
    add_reg(REG_UNUSED_7, SUM_MAX);
    add_beat(MODE_QRY, 12'd1, 24'd0, 1'b0);
    add_reg(REG_MAX_MITO, 44'(FRAC_ONE));
    add_reg(REG_THRESHOLD, 44'd0);
    add_beat(MODE_QRY, 12'd1, 24'd0, 1'b0);
    // an update and then a query of one column, back to back unless a random sender gap falls between
    add_beat(MODE_CLR, 12'd0, 24'd0, 1'b0);
    add_beat(MODE_ACC, 12'd2, 24'd1, 1'b1);
    add_beat(MODE_QRY, 12'd2, 24'd0, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        await_quiet();
        write_limit(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        issue_beat(directed_rows[i].beat);
        if (directed_rows[i].typed)
          pending_reports.insert(pending_reports.size(), directed_rows[i].want);
        else
          track_beat(directed_rows[i].beat);
        sender_gap(31);
      end
    end

    // burst of full-scale entries on one column, back to back
    b = item_t'{MODE_ACC, 12'd3, 24'hFFFFFF, 1'b1};
    for (int n = 0; n < BURST_BEATS; n++) begin
      issue_beat(b);
      track_beat(b);
    end
    b = item_t'{MODE_QRY, 12'd3, 24'd0, 1'b0};
    issue_beat(b);
    track_beat(b);

    // random phases, mostly on a few hot columns so the sums build up
    for (int p = 0; p < PHASES; p++) begin
      await_quiet();
      load_phase_limits(p);
      foreach (hot[i]) hot[i] = COL_W'($urandom);
      if (p == 3) hot[0] = 12'd3;
      if (p == 4) begin
        hot[1] = '0;
        hot[2] = '1;
      end
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        sel = $urandom_range(99);
        b.mode = (sel < 60) ? MODE_ACC : (sel < 85) ? MODE_QRY :
                 (sel < 93) ? MODE_CLR : MODE_NONE;
        b.column = ($urandom_range(99) < 85) ? hot[$urandom_range(HOT_COLS - 1)]
                                             : COL_W'($urandom);
        sel = $urandom_range(9);
        if (sel < 4) begin
          // close to the threshold on either side
          near = longint'(lim.threshold) + longint'(int'($urandom_range(8))) - 4;
          if (near < 0)
            near = 0;
          else if (near > longint'(24'hFFFFFF))
            near = longint'(24'hFFFFFF);
          b.value = VAL_W'(near);
        end else if (sel < 7) begin
          b.value = VAL_W'($urandom);
        end else if (sel < 9) begin
          b.value = VAL_W'($urandom_range(255));
        end else begin
          b.value = ($urandom_range(1) == 1) ? {VAL_W{1'b1}} : '0;
        end
        b.row_is_mito = 1'($urandom_range(1));
        issue_beat(b);
        track_beat(b);
        if (k == 97 || $urandom_range(49) == 0)
          await_quiet();
        else
          sender_gap(IDLE_PCT[p]);
      end
    end

    await_quiet();
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
      mismatches += pending_reports.size();
    end
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
